[hdl/b2b_pkg.sv]
`timescale 1ns / 1ps
package b2b_pkg;
  localparam logic [1:0] REQ_KEY = 2'd0;
  localparam logic [1:0] REQ_MSG = 2'd1;
  localparam logic [1:0] REQ_FIN = 2'd2;
  localparam logic [1:0] REQ_BAD = 2'd3;
  localparam logic CFG_DLEN = 1'b0;
  localparam logic CFG_KLEN = 1'b1;

  localparam logic [511:0] IV = {
    64'h5BE0CD19137E2179, 64'h1F83D9ABFB41BD6B,
    64'h9B05688C2B3E6C1F, 64'h510E527FADE682D1,
    64'hA54FF53A5F1D36F1, 64'h3C6EF372FE94F82B,
    64'hBB67AE8584CAA73B, 64'h6A09E667F3BCC908};

  localparam logic [639:0] SIGMA = {
    64'h0dc3e9bf5167482a, 64'h5a417d2c803b9ef6,
    64'ha2684f05931ce7bd, 64'hb8293670a4def15c,
    64'h91ef57d438b0a6c2, 64'hd386cb1efa427509,
    64'h8f04a562ebcd1397, 64'h491763eadf250c8b,
    64'h357b20c16df984ae, 64'hfedcba9876543210};

  // a,b,c,d indexes per G step, nibbles d c b a
  localparam logic [127:0] MIX = {
    16'he943, 16'hd872, 16'hcb61, 16'hfa50,
    16'hfb73, 16'hea62, 16'hd951, 16'hc840};

  typedef struct packed {
    logic start;     // reinit run
    logic put;       // write byte at pos
    logic [7:0] pbyte;
    logic cmp_go;    // start compression
    logic cmp_last;
    logic cnt_add;   // byte_count += pos or 128
    logic cnt_full;
    logic close_key; // pos <- 128
    logic pos_zero;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic [7:0] pos;
    logic key_open;
  } stat_t;

  function automatic logic [6:0] eff_dl(input logic [6:0] v);
    if (v == 7'd0) return 7'd1;
    if (v > 7'd64) return 7'd64;
    return v;
  endfunction

  function automatic logic [6:0] eff_kl(input logic [6:0] v);
    return (v > 7'd64) ? 7'd64 : v;
  endfunction
endpackage

[hdl/b2b_if.sv]
`timescale 1ns / 1ps
interface b2b_in_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  modport source(output valid, req_type, data_byte, input ready);
  modport sink(input valid, req_type, data_byte, output ready);
endinterface

interface b2b_out_if;
  logic valid;
  logic ready;
  logic [7:0] digest_byte;
  logic [5:0] digest_index;
  logic digest_last;
  modport source(output valid, digest_byte, digest_index, digest_last, input ready);
  modport sink(input valid, digest_byte, digest_index, digest_last, output ready);
endinterface

interface b2b_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [6:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[hdl/b2b_datapath.sv]
`timescale 1ns / 1ps
module b2b_datapath (
  input  logic clk,
  input  b2b_pkg::cmd_t cmd,
  input  logic [6:0] dlen,
  input  logic [6:0] klen,
  input  logic [5:0] rd_idx,
  output logic [7:0] rd_byte,
  output b2b_pkg::stat_t stat
);
  logic [63:0] h [8];
  logic [63:0] m [16];
  logic [63:0] v [16];
  logic [7:0] pos;
  logic [63:0] cnt;
  logic key_open;
  logic busy;
  logic [3:0] rnd;   // 0..11
  logic [2:0] gi;    // G step
  logic [1:0] ph;    // half 0/1 of G: each half does a+b+x, rot d, c+d, rot b

  logic [3:0] ia, ib, ic, id, sx;
  logic [3:0] rrow;
  logic [63:0] row, xm, a1, d1, c1, b1;
  logic [63:0] dd, bb;
  logic [63:0] cnt_sum;  // counter as the starting compression sees it
  logic [63:0] pword;    // parameter word folded into h[0]

  always_comb begin
    rrow = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
    row = b2b_pkg::SIGMA[rrow*64 +: 64];
    ia = b2b_pkg::MIX[gi*16 +: 4];
    ib = b2b_pkg::MIX[gi*16+4 +: 4];
    ic = b2b_pkg::MIX[gi*16+8 +: 4];
    id = b2b_pkg::MIX[gi*16+12 +: 4];
    sx = row[{gi, ph[0], 2'b00} +: 4];
    xm = m[sx];
    a1 = v[ia] + v[ib] + xm;
    dd = v[id] ^ a1;
    d1 = ph[0] ? {dd[15:0], dd[63:16]} : {dd[31:0], dd[63:32]};
    c1 = v[ic] + d1;
    bb = v[ib] ^ c1;
    b1 = ph[0] ? {bb[62:0], bb[63]} : {bb[23:0], bb[63:24]};
    cnt_sum = cmd.cnt_add ? cnt + (cmd.cnt_full ? 64'd128 : {56'd0, pos}) : cnt;
    pword = 64'h01010000 ^ {49'd0, b2b_pkg::eff_kl(klen), 8'd0}
            ^ {57'd0, b2b_pkg::eff_dl(dlen)};
  end

  assign stat.busy = busy;
  assign stat.pos = pos;
  assign stat.key_open = key_open;
  assign rd_byte = h[rd_idx[5:3]][{rd_idx[2:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      for (int i = 0; i < 8; i++) h[i] <= b2b_pkg::IV[i*64 +: 64] ^ ((i == 0) ? pword : 64'd0);
      for (int i = 0; i < 16; i++) m[i] <= '0;
      pos <= '0;
      cnt <= '0;
      key_open <= (b2b_pkg::eff_kl(klen) != 7'd0);
      busy <= 1'b0;
    end else if (cmd.cmp_go) begin
      for (int i = 0; i < 8; i++) begin
        v[i] <= h[i];
        v[i+8] <= b2b_pkg::IV[i*64 +: 64] ^ ((i == 4) ? cnt_sum : 64'd0)
                  ^ ((i == 6) ? {64{cmd.cmp_last}} : 64'd0);
      end
      cnt <= cnt_sum;
      rnd <= '0; gi <= '0; ph <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      if (ph == 2'd2) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] ^ v[i] ^ v[i+8];
        busy <= 1'b0;
      end else begin
        v[ia] <= a1; v[id] <= d1; v[ic] <= c1; v[ib] <= b1;
        if (ph[0]) begin
          ph <= 2'd0;
          gi <= gi + 3'd1;
          if (gi == 3'd7) begin
            if (rnd == 4'd11) ph <= 2'd2;
            else rnd <= rnd + 4'd1;
          end
        end else ph <= 2'd1;
      end
    end else begin
      if (cmd.close_key) begin
        pos <= 8'd128;
        key_open <= 1'b0;
      end else if (cmd.pos_zero) begin
        // new block starts empty so the final padding reads zeros
        pos <= 8'd0;
        for (int i = 0; i < 16; i++) m[i] <= '0;
      end else if (cmd.put) begin
        m[pos[6:3]][{pos[2:0], 3'b000} +: 8] <= cmd.pbyte;
        pos <= pos + 8'd1;
      end
    end
  end
endmodule

[hdl/b2b_ctrl.sv]
`timescale 1ns / 1ps
module b2b_ctrl (
  input  logic clk,
  input  logic rst,
  b2b_in_if.sink  in_ch,
  b2b_out_if.source out_ch,
  b2b_cfg_if.sink cfg_ch,
  input  b2b_pkg::stat_t stat,
  input  logic [7:0] rd_byte,
  output logic [5:0] rd_idx,
  output logic [6:0] dlen,
  output logic [6:0] klen,
  output b2b_pkg::cmd_t cmd
);
  typedef enum logic [5:0] {
    S_INIT = 6'b000001, S_IDLE = 6'b000010, S_PAD = 6'b000100,
    S_CMP  = 6'b001000, S_WAIT = 6'b010000, S_EMIT = 6'b100000
  } state_t;
  state_t state, state_next;
  logic fin;          // compression is the final one
  logic [7:0] hold;   // pending message byte
  logic [6:0] cnt;    // digest bytes issued
  logic cfg_fire, in_fire, out_fire;
  logic [1:0] rt;

  assign cfg_ch.ready = (state == S_IDLE);
  assign in_ch.ready = (state == S_IDLE) && !cfg_ch.valid;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign rt = in_ch.req_type;
  assign rd_idx = cnt[5:0];
  assign out_ch.valid = (state == S_EMIT);
  assign out_ch.digest_byte = rd_byte;
  assign out_ch.digest_index = cnt[5:0];
  assign out_ch.digest_last = (cnt + 7'd1 == b2b_pkg::eff_dl(dlen));

  always_comb begin
    cmd = '0;
    cmd.pbyte = in_ch.data_byte;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.start = 1'b1;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_fire) state_next = S_INIT;
        else if (in_fire) begin
          unique case (rt)
            b2b_pkg::REQ_KEY:
              cmd.put = stat.key_open && (stat.pos < {1'b0, b2b_pkg::eff_kl(klen)});
            b2b_pkg::REQ_MSG, b2b_pkg::REQ_FIN: begin
              if (stat.key_open) cmd.close_key = 1'b1;
              else if (rt == b2b_pkg::REQ_MSG && !stat.pos[7]) cmd.put = 1'b1;
              // counter is added together with the compression start in PAD
              if (stat.key_open || stat.pos[7] || rt == b2b_pkg::REQ_FIN)
                state_next = S_PAD;
            end
            default: ;
          endcase
        end
      end
      S_PAD: begin
        // tail bytes are already zero: buffer cleared at start and after compress
        if (fin) begin
          cmd.cnt_add = 1'b1;
          cmd.cmp_go = 1'b1; cmd.cmp_last = 1'b1;
          state_next = S_CMP;
        end else if (stat.pos[7]) begin
          cmd.cnt_add = 1'b1; cmd.cnt_full = 1'b1;
          cmd.cmp_go = 1'b1;
          state_next = S_CMP;
        end else begin
          cmd.put = 1'b1; cmd.pbyte = hold;
          state_next = S_IDLE;
        end
      end
      S_CMP: state_next = S_WAIT;
      S_WAIT: if (!stat.busy) begin
        if (fin) state_next = S_EMIT;
        else begin
          cmd.pos_zero = 1'b1;
          state_next = S_PAD;
        end
      end
      S_EMIT: if (out_fire && out_ch.digest_last) state_next = S_INIT;
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      dlen <= 7'd64;
      klen <= 7'd0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        if (cfg_ch.index == b2b_pkg::CFG_DLEN) dlen <= cfg_ch.data;
        else klen <= cfg_ch.data;
      end
      if (in_fire) begin
        hold <= in_ch.data_byte;
        fin <= (rt == b2b_pkg::REQ_FIN);
      end
      if (state == S_IDLE) cnt <= '0;
      else if (out_fire) cnt <= cnt + 7'd1;
    end
  end
endmodule

[hdl/blake2b_keyed_hash_stream_top.sv]
`timescale 1ns / 1ps
// BLAKE2b keyed/unkeyed hash over a byte stream.
// in: one item per byte; req_type key(0), message(1), finalize(2).
// out: digest_length items after each finalize, index 0 up, last flagged.
// cfg: index 0 digest_length, 1 key_length; a write restarts the run.
// Absorbing takes one cycle per byte. When a message byte finds the
// buffer full or the key block open, the compression runs first:
// 12 rounds x 8 G steps x 2 half-steps on one shared G unit plus the
// chain update. in stays not ready from that byte on through PAD
// (compression start), CMP, WAIT until the compression ends and PAD
// again to store the held byte. Finalize runs the last compression
// through PAD, CMP and WAIT, then EMIT offers the digest one item per
// cycle as the receiver takes them; a stall on out holds the item.
// After reset (synchronous, rst high) a one-cycle init loads IV and the
// parameter word before any item is taken; the same init follows each
// config write and the last digest item. The block accepts nothing
// while compressing or emitting.
module blake2b_keyed_hash_stream_top (
  input logic clk,
  input logic rst,
  b2b_in_if.sink in_ch,
  b2b_out_if.source out_ch,
  b2b_cfg_if.sink cfg_ch
);
  b2b_pkg::cmd_t cmd;
  b2b_pkg::stat_t stat;
  logic [5:0] rd_idx;
  logic [7:0] rd_byte;
  logic [6:0] dlen, klen;

  b2b_ctrl u_ctrl (.clk, .rst, .in_ch, .out_ch, .cfg_ch, .stat, .rd_byte,
                   .rd_idx, .dlen, .klen, .cmd);
  b2b_datapath u_dp (.clk, .cmd, .dlen, .klen, .rd_idx, .rd_byte, .stat);
endmodule
